/* rtl/wlsg_pkg.sv */
// shared types, widths and helpers for the weighted least-squares gradient block
`timescale 1ns / 1ps
package wlsg_pkg;

  // field widths
  localparam int ACC_W  = 64;   // accumulator width
  localparam int OFS_W  = 32;   // offset, Q8.24
  localparam int VAL_W  = 32;   // value difference, Q16.16
  localparam int GRD_W  = 40;   // gradient, Q16.24

  // per-entry datapath
  localparam int A_W    = 21;   // normalized offset magnitude
  localparam int LEN_W  = 44;   // squared length of the normalized offset
  localparam int QW     = 23;   // quotient bits of one entry division
  localparam int RP_W   = QW + VAL_W;
  localparam int FRAC_M = 20;

  // solve datapath
  localparam int TR_W   = 19;   // scaled matrix magnitude / trace bound
  localparam int M_W    = TR_W + 1;
  localparam int RL_W   = 22;   // scaled rhs magnitude bound
  localparam int RS_W   = RL_W + 1;
  localparam int MP_W   = 39;
  localparam int COF_W  = 40;
  localparam int TSQ_W  = 2 * TR_W;
  localparam int CUBE_W = 3 * TR_W;
  localparam int DTP_W  = 59;
  localparam int DT_W   = 61;
  localparam int DM_W   = 60;
  localparam int NP_W   = 62;
  localparam int NUM_W  = 64;
  localparam int NM_W   = 63;
  localparam int TH_W   = 18;   // |det| at or above 2^18 always passes the test
  localparam int CNT_W  = 7;
  localparam int DIV_BASE = NM_W + FRAC_M;

  localparam logic [39:0] THRESH_DIV = 40'd1000000000000;

  // matrix term index pairs: xx, xy, xz, yy, yz, zz
  localparam int PAIR_I [6] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [6] = '{0, 1, 2, 1, 2, 2};

  // cofactor order: cx, cy, cz, c22, c23, c33; numerator j uses cof[NUM_COF[j]] * rhs[j % 3]
  localparam int NUM_COF [9] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};

  typedef struct packed {
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic signed [OFS_W-1:0] offset_z;
    logic signed [VAL_W-1:0] value_difference;
    logic                    is_boundary;
    logic                    last_entry;
  } item_t;

  typedef struct packed {
    logic signed [GRD_W-1:0] grad_x;
    logic signed [GRD_W-1:0] grad_y;
    logic signed [GRD_W-1:0] grad_z;
    logic                    gradient_valid;
  } result_t;

  // classified entry travelling from front to back
  typedef struct packed {
    logic [2:0][A_W-1:0] amag;
    logic [2:0]          aneg;
    logic [VAL_W-1:0]    vmag;
    logic                vneg;
    logic signed [5:0]   vshift;
    logic                skip;
    logic                last;
  } entry_t;

  // finished sums handed to the solver
  typedef struct packed {
    logic                  go;
    logic [5:0][ACC_W-1:0] nsum;
    logic [2:0][ACC_W-1:0] rsum;
  } handoff_t;

  // saturating add of a signed magnitude into a signed accumulator
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [ACC_W-1:0] mag,
                                               input logic neg);
    logic [ACC_W-1:0] b;
    logic [ACC_W:0]   s;
    b = mag[ACC_W-1] ? {1'b0, {(ACC_W-1){1'b1}}} : mag;
    s = neg ? ({acc[ACC_W-1], acc} - {1'b0, b}) : ({acc[ACC_W-1], acc} + {1'b0, b});
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = neg ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

endpackage

/* rtl/weighted_least_squares_cell_gradient_core.sv */
// top level of the weighted least-squares cell gradient block
// an included entry occupies the accumulator through multiply, length, division in the shared
// divider lanes, rhs multiply and accumulate; a skipped entry bypasses all of these. the front
// end takes an entry each cycle into a two-entry queue while it has room. the last entry adds
// the solve: shift search, fixed steps and gradient division, then the result waits in its register.
// synchronous active-high reset clears the sums, queue and sequencers; mode resets to 1.
`timescale 1ns / 1ps
module weighted_least_squares_cell_gradient_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic              cfg_write_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  wlsg_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output wlsg_pkg::result_t result
);
  import wlsg_pkg::*;

  entry_t   q_in;
  entry_t   q_head;
  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_valid;
  handoff_t hand;
  logic     solve_ready;

  // classify and normalize
  wlsg_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item           (item),
    .item_stall     (item_stall),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_in)
  );

  // decoupling queue
  wlsg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .head  (q_head)
  );

  // weights and sums
  wlsg_accum u_accum (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .solve_ready (solve_ready),
    .hand        (hand)
  );

  // inverse and gradient
  wlsg_solve u_solve (
    .clk          (clk),
    .rst          (rst),
    .hand         (hand),
    .ready        (solve_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* rtl/wlsg_front.sv */
// front end: accepts entries, classifies skips and normalizes the offset
`timescale 1ns / 1ps
module wlsg_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write_en,
  input  logic             cfg_write_data,
  input  logic             item_valid,
  input  wlsg_pkg::item_t  item,
  output logic             item_stall,
  input  logic             q_full,
  output logic             q_push,
  output wlsg_pkg::entry_t q_entry
);
  import wlsg_pkg::*;

  logic             use_bnd;
  logic [OFS_W-1:0] raw [3];
  logic [OFS_W-1:0] mg [3];
  logic [OFS_W-1:0] ored;
  logic [VAL_W-1:0] vraw;
  logic [5:0]       bl;
  logic signed [6:0] sh;
  logic [6:0]       nsh;

  // boundary mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      use_bnd <= 1'b1;
    end else if (cfg_write_en) begin
      use_bnd <= cfg_write_data;
    end
  end

  // transfer into the queue whenever it has room
  assign item_stall = q_full;
  assign q_push     = item_valid & ~q_full;

  // sign split, scale exponent and normalized magnitudes
  always_comb begin
    raw[0] = item.offset_x;
    raw[1] = item.offset_y;
    raw[2] = item.offset_z;
    for (int i = 0; i < 3; i++) begin
      q_entry.aneg[i] = raw[i][OFS_W-1];
      mg[i] = raw[i][OFS_W-1] ? (~raw[i] + 1'b1) : raw[i];
    end
    ored = mg[0] | mg[1] | mg[2];
    bl = '0;
    for (int b = 0; b < OFS_W; b++) begin
      if (ored[b]) bl = 6'(b + 1);
    end
    sh  = 7'sd21 - $signed({1'b0, bl});
    nsh = -sh;
    for (int i = 0; i < 3; i++) begin
      q_entry.amag[i] = sh[6] ? A_W'(mg[i] >> nsh) : A_W'(mg[i] << sh[4:0]);
    end
    vraw           = item.value_difference;
    q_entry.vneg   = vraw[VAL_W-1];
    q_entry.vmag   = vraw[VAL_W-1] ? (~vraw + 1'b1) : vraw;
    q_entry.vshift = 6'(sh - 7'sd10);
    q_entry.skip   = (ored == '0) | (item.is_boundary & ~use_bnd);
    q_entry.last   = item.last_entry;
  end

endmodule

/* rtl/wlsg_queue.sv */
// two-entry queue between the front end and the accumulator
`timescale 1ns / 1ps
module wlsg_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wlsg_pkg::entry_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output wlsg_pkg::entry_t head
);
  import wlsg_pkg::*;

  entry_t     slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign valid = (cnt != 2'd0);
  assign head  = slot[rp];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slot[wp] <= wdata;
  end

endmodule

/* rtl/wlsg_accum.sv */
// back end part one: per-entry weights by shared division lanes and saturating sums
`timescale 1ns / 1ps
module wlsg_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  wlsg_pkg::entry_t   q_head,
  output logic               q_pop,
  input  logic               solve_ready,
  output wlsg_pkg::handoff_t hand
);
  import wlsg_pkg::*;

  typedef enum logic [2:0] {A_IDLE, A_MUL, A_LEN, A_DIV, A_RMUL, A_ACC, A_HAND} state_t;

  state_t            state;
  entry_t            cur;
  logic [2*A_W-1:0]  prod [6];
  logic [LEN_W-1:0]  len2;
  logic [LEN_W-1:0]  rem [9];
  logic [QW-1:0]     dvd [9];
  logic [QW-1:0]     quo [9];
  logic [4:0]        step;
  logic [RP_W-1:0]   rprod [3];
  logic [ACC_W-1:0]  nsum [6];
  logic [ACC_W-1:0]  rsum [3];
  logic [LEN_W:0]    trial [9];
  logic [8:0]        ge;
  logic [ACC_W-1:0]  rsh [3];
  logic [5:0]        nvs;

  assign q_pop = (state == A_IDLE) & q_valid;

  // division trial step, rhs scaling, handoff payload
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      trial[l] = {rem[l], dvd[l][QW-1]};
      ge[l]    = (trial[l] >= {1'b0, len2});
    end
    nvs = 6'(-cur.vshift);
    for (int i = 0; i < 3; i++) begin
      rsh[i] = cur.vshift[5] ? (ACC_W'(rprod[i]) >> nvs) : (ACC_W'(rprod[i]) << cur.vshift[3:0]);
    end
    hand.go = (state == A_HAND);
    for (int p = 0; p < 6; p++) hand.nsum[p] = nsum[p];
    for (int i = 0; i < 3; i++) hand.rsum[i] = rsum[i];
  end

  // entry sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      for (int p = 0; p < 6; p++) nsum[p] <= '0;
      for (int i = 0; i < 3; i++) rsum[i] <= '0;
    end else begin
      case (state)
        A_IDLE: begin
          if (q_valid) begin
            cur <= q_head;
            if (q_head.skip) begin
              state <= q_head.last ? A_HAND : A_IDLE;
            end else begin
              state <= A_MUL;
            end
          end
        end
        A_MUL: begin
          for (int p = 0; p < 6; p++) begin
            prod[p] <= cur.amag[PAIR_I[p]] * cur.amag[PAIR_J[p]];
          end
          state <= A_LEN;
        end
        A_LEN: begin
          len2 <= LEN_W'(prod[0]) + LEN_W'(prod[3]) + LEN_W'(prod[5]);
          // dividend high part already below the length, low bits streamed in
          for (int p = 0; p < 6; p++) begin
            rem[p] <= LEN_W'(prod[p][2*A_W-1:3]);
            dvd[p] <= {prod[p][2:0], {FRAC_M{1'b0}}};
          end
          for (int i = 0; i < 3; i++) begin
            rem[6+i] <= LEN_W'({cur.amag[i], 19'b0});
            dvd[6+i] <= '0;
          end
          for (int l = 0; l < 9; l++) quo[l] <= '0;
          step  <= '0;
          state <= A_DIV;
        end
        A_DIV: begin
          for (int l = 0; l < 9; l++) begin
            rem[l] <= ge[l] ? LEN_W'(trial[l] - {1'b0, len2}) : trial[l][LEN_W-1:0];
            quo[l] <= {quo[l][QW-2:0], ge[l]};
            dvd[l] <= dvd[l] << 1;
          end
          step <= step + 5'd1;
          if (step == 5'(QW - 1)) state <= A_RMUL;
        end
        A_RMUL: begin
          for (int i = 0; i < 3; i++) rprod[i] <= quo[6+i] * cur.vmag;
          state <= A_ACC;
        end
        A_ACC: begin
          for (int p = 0; p < 6; p++) begin
            nsum[p] <= sat_add(nsum[p], ACC_W'(quo[p]),
                               cur.aneg[PAIR_I[p]] ^ cur.aneg[PAIR_J[p]]);
          end
          for (int i = 0; i < 3; i++) begin
            rsum[i] <= sat_add(rsum[i], rsh[i], cur.aneg[i] ^ cur.vneg);
          end
          state <= cur.last ? A_HAND : A_IDLE;
        end
        A_HAND: begin
          if (solve_ready) begin
            for (int p = 0; p < 6; p++) nsum[p] <= '0;
            for (int i = 0; i < 3; i++) rsum[i] <= '0;
            state <= A_IDLE;
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wlsg_solve.sv */
// back end part two: scaling, cofactor inverse, determinant test and gradient division
`timescale 1ns / 1ps
module wlsg_solve (
  input  logic               clk,
  input  logic               rst,
  input  wlsg_pkg::handoff_t hand,
  output logic               ready,
  output logic               result_valid,
  input  logic               result_stall,
  output wlsg_pkg::result_t  result
);
  import wlsg_pkg::*;

  typedef enum logic [3:0] {S_IDLE, S_SRCH, S_SCALE, S_PROD, S_COF, S_DTP, S_DTS, S_THR,
                            S_NUMP, S_NUMS, S_DIV, S_FIN, S_OUT} state_t;

  state_t                   state;
  logic [ACC_W-1:0]         nraw [6];
  logic [ACC_W-1:0]         rm [3];
  logic [2:0]               rn;
  logic [ACC_W-1:0]         rbig;
  logic [5:0]               k;
  logic [5:0]               r;
  logic signed [M_W-1:0]    m [6];
  logic signed [RS_W-1:0]   rs [3];
  logic signed [MP_W-1:0]   mp [12];
  logic [TR_W-1:0]          trace;
  logic signed [COF_W-1:0]  cof [6];
  logic [TSQ_W-1:0]         tsq;
  logic signed [DTP_W-1:0]  dtp [3];
  logic [CUBE_W-1:0]        cube;
  logic signed [DT_W-1:0]   dt;
  logic [DM_W-1:0]          dmag;
  logic signed [NP_W-1:0]   nump [9];
  logic [NM_W-1:0]          nmag [3];
  logic [2:0]               nneg;
  logic [DM_W-1:0]          rem [3];
  logic [GRD_W-1:0]         q [3];
  logic [2:0]               sat;
  logic [CNT_W-1:0]         cnt;
  result_t                  res;

  logic [ACC_W-1:0]         rin [3];
  logic [ACC_W-1:0]         rmax01;
  logic [ACC_W-1:0]         dgk [3];
  logic [ACC_W+1:0]         dsum;
  logic                     kcond;
  logic                     rcond;
  logic [ACC_W-1:0]         pmag [6];
  logic [ACC_W-1:0]         psh [6];
  logic [TR_W-1:0]          pcl [6];
  logic [ACC_W-1:0]         rsh [3];
  logic [DT_W-1:0]          dabs;
  logic [57:0]              thrp;
  logic                     det_fail;
  logic signed [NUM_W-1:0]  gnum [3];
  logic [NUM_W-1:0]         gabs [3];
  logic [DM_W:0]            trial [3];
  logic [2:0]               ge;
  logic [GRD_W-1:0]         cap [3];
  logic [GRD_W-1:0]         qf [3];

  assign ready        = (state == S_IDLE);
  assign result_valid = (state == S_OUT);
  assign result       = res;

  always_comb begin
    // rhs magnitudes and their maximum at handoff
    for (int i = 0; i < 3; i++) begin
      rin[i] = hand.rsum[i][ACC_W-1] ? (~hand.rsum[i] + 1'b1) : hand.rsum[i];
    end
    rmax01 = (rin[0] > rin[1]) ? rin[0] : rin[1];
    // matrix shift search on the clipped diagonal
    dgk[0] = nraw[0][ACC_W-1] ? '0 : (nraw[0] >> k);
    dgk[1] = nraw[3][ACC_W-1] ? '0 : (nraw[3] >> k);
    dgk[2] = nraw[5][ACC_W-1] ? '0 : (nraw[5] >> k);
    dsum   = (ACC_W+2)'(dgk[0]) + (ACC_W+2)'(dgk[1]) + (ACC_W+2)'(dgk[2]);
    kcond  = (dgk[0][ACC_W-1:TR_W] == '0) && (dgk[1][ACC_W-1:TR_W] == '0) &&
             (dgk[2][ACC_W-1:TR_W] == '0) && (dsum[ACC_W+1:TR_W] == '0);
    rcond  = ((rbig >> r) >> RL_W) == '0;
    // scaled and clamped matrix terms
    for (int p = 0; p < 6; p++) begin
      pmag[p] = nraw[p][ACC_W-1] ? (~nraw[p] + 1'b1) : nraw[p];
      psh[p]  = pmag[p] >> k;
      pcl[p]  = (psh[p][ACC_W-1:TR_W] != '0) ? {TR_W{1'b1}} : psh[p][TR_W-1:0];
      if (PAIR_I[p] == PAIR_J[p] && nraw[p][ACC_W-1]) pcl[p] = '0;
    end
    for (int i = 0; i < 3; i++) rsh[i] = rm[i] >> r;
    // determinant threshold: |det| * 1e12 < trace^3 fails
    dabs     = dt[DT_W-1] ? (~dt + 1'b1) : dt;
    thrp     = dmag[TH_W-1:0] * THRESH_DIV;
    det_fail = (dmag[DM_W-1:TH_W] == '0) && (thrp < {1'b0, cube});
    // numerators
    for (int g = 0; g < 3; g++) begin
      gnum[g] = nump[3*g] + nump[3*g+1] + nump[3*g+2];
      gabs[g] = gnum[g][NUM_W-1] ? (~gnum[g] + 1'b1) : gnum[g];
    end
    // division lanes and final saturation
    for (int g = 0; g < 3; g++) begin
      trial[g] = {rem[g], nmag[g][NM_W-1]};
      ge[g]    = (trial[g] >= {1'b0, dmag});
      cap[g]   = nneg[g] ? {1'b1, {(GRD_W-1){1'b0}}} : {1'b0, {(GRD_W-1){1'b1}}};
      qf[g]    = (sat[g] || q[g] > cap[g]) ? cap[g] : q[g];
    end
  end

  // solve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (hand.go) begin
            for (int p = 0; p < 6; p++) nraw[p] <= hand.nsum[p];
            for (int i = 0; i < 3; i++) begin
              rm[i] <= rin[i];
              rn[i] <= hand.rsum[i][ACC_W-1];
            end
            rbig  <= (rmax01 > rin[2]) ? rmax01 : rin[2];
            k     <= '0;
            r     <= '0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (!kcond) k <= k + 6'd1;
          if (!rcond) r <= r + 6'd1;
          if (kcond && rcond) state <= S_SCALE;
        end
        S_SCALE: begin
          for (int p = 0; p < 6; p++) begin
            m[p] <= nraw[p][ACC_W-1] ? -$signed({1'b0, pcl[p]}) : $signed({1'b0, pcl[p]});
          end
          for (int i = 0; i < 3; i++) begin
            rs[i] <= rn[i] ? -$signed({1'b0, rsh[i][RL_W-1:0]}) : $signed({1'b0, rsh[i][RL_W-1:0]});
          end
          state <= S_PROD;
        end
        S_PROD: begin
          mp[0]  <= m[3] * m[5];
          mp[1]  <= m[4] * m[4];
          mp[2]  <= m[2] * m[4];
          mp[3]  <= m[1] * m[5];
          mp[4]  <= m[1] * m[4];
          mp[5]  <= m[3] * m[2];
          mp[6]  <= m[0] * m[5];
          mp[7]  <= m[2] * m[2];
          mp[8]  <= m[1] * m[2];
          mp[9]  <= m[0] * m[4];
          mp[10] <= m[0] * m[3];
          mp[11] <= m[1] * m[1];
          trace  <= TR_W'(m[0] + m[3] + m[5]);
          state  <= S_COF;
        end
        S_COF: begin
          for (int c = 0; c < 6; c++) cof[c] <= mp[2*c] - mp[2*c+1];
          tsq <= trace * trace;
          if (trace == '0) begin
            res   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_DTP;
          end
        end
        S_DTP: begin
          dtp[0] <= m[0] * cof[0];
          dtp[1] <= m[1] * cof[1];
          dtp[2] <= m[2] * cof[2];
          cube   <= tsq * trace;
          state  <= S_DTS;
        end
        S_DTS: begin
          dt    <= dtp[0] + dtp[1] + dtp[2];
          state <= S_THR;
        end
        S_THR: begin
          dmag  <= dabs[DM_W-1:0];
          state <= S_NUMP;
        end
        S_NUMP: begin
          if (det_fail) begin
            res   <= '0;
            state <= S_OUT;
          end else begin
            for (int j = 0; j < 9; j++) nump[j] <= cof[NUM_COF[j]] * rs[j % 3];
            state <= S_NUMS;
          end
        end
        S_NUMS: begin
          for (int g = 0; g < 3; g++) begin
            nmag[g] <= gabs[g][NM_W-1:0];
            nneg[g] <= gnum[g][NUM_W-1] ^ dt[DT_W-1];
            rem[g]  <= '0;
            q[g]    <= '0;
          end
          sat   <= '0;
          cnt   <= CNT_W'(DIV_BASE) - CNT_W'(k) + CNT_W'(r);
          state <= S_DIV;
        end
        S_DIV: begin
          for (int g = 0; g < 3; g++) begin
            rem[g]  <= ge[g] ? DM_W'(trial[g] - {1'b0, dmag}) : trial[g][DM_W-1:0];
            q[g]    <= {q[g][GRD_W-2:0], ge[g]};
            sat[g]  <= sat[g] | q[g][GRD_W-1];
            nmag[g] <= nmag[g] << 1;
          end
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) state <= S_FIN;
        end
        S_FIN: begin
          res.grad_x         <= nneg[0] ? -qf[0] : qf[0];
          res.grad_y         <= nneg[1] ? -qf[1] : qf[1];
          res.grad_z         <= nneg[2] ? -qf[2] : qf[2];
          res.gradient_valid <= 1'b1;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (!result_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/wlsg_checker.sv */
// port-level checks for the gradient block, bound to the top level
`timescale 1ns / 1ps
module wlsg_checker (
  input logic              clk,
  input logic              rst,
  input logic              cfg_write_en,
  input logic              cfg_write_data,
  input logic              item_valid,
  input logic              item_stall,
  input wlsg_pkg::item_t   item,
  input logic              result_valid,
  input logic              result_stall,
  input wlsg_pkg::result_t result
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a deficient stencil reports a zero gradient
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.gradient_valid |->
      result.grad_x == '0 && result.grad_y == '0 && result.grad_z == '0)
    else $error("invalid gradient not zero");

  // nothing pending right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // no input stall right after reset
  a_rst_in: assert property (@(posedge clk) rst |=> !item_stall)
    else $error("input stalled after reset");

endmodule

bind weighted_least_squares_cell_gradient_core wlsg_checker u_wlsg_checker (.*);

/* test/gradient_checker.sv */
// transfer monitor, gradient predictor and result comparison for the gradient core
`timescale 1ns / 1ps
module gradient_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic              cfg_write_data,
  input  logic              item_valid,
  input  logic              item_stall,
  input  wlsg_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  wlsg_pkg::result_t result,
  output int                errors,
  output int                pending
);
  import wlsg_pkg::*;

  localparam logic [63:0] SUM_MAX   = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] TERM_LIM  = 64'd1 << 19;
  localparam logic [63:0] RHS_BOUND = 64'd1 << 22;
  localparam logic [63:0] DET_DIV   = 64'd1000000000000;
  localparam logic [63:0] GRAD_POS  = (64'd1 << 39) - 1;
  localparam logic [63:0] GRAD_NEG  = 64'd1 << 39;
  localparam int          ROW [6]   = '{0, 0, 0, 1, 1, 2};
  localparam int          COL [6]   = '{0, 1, 2, 1, 2, 2};

  bit          include_boundary;
  longint      mat_sum [6];
  longint      rhs_sum [3];
  result_t     gradient_queue [$];

  // saturating signed accumulate
  function automatic longint sat_sum(longint acc, logic [63:0] mag, bit neg);
    longint hi, lo, b;
    hi = SUM_MAX;
    lo = -hi - 1;
    if (mag > SUM_MAX) mag = SUM_MAX;
    b = mag;
    if (!neg) return (acc > hi - b) ? hi : acc + b;
    return (acc < lo + b) ? lo : acc - b;
  endfunction

  function automatic void split_word(logic [31:0] raw, output logic [63:0] mag, output bit neg);
    neg = raw[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
  endfunction

  function automatic void split_long(longint v, output logic [63:0] mag, output bit neg);
    neg = v < 0;
    mag = neg ? (64'd0 - v) : v;
  endfunction

  // weighted outer product and rhs contribution of one entry
  function automatic void accumulate_entry(item_t it);
    logic [63:0] mg [3];
    logic [63:0] a [3];
    logic [63:0] big, len2, t, w, prod, mag, vm, tmp;
    bit          ng [3];
    bit          vn;
    int          bl, sh, s;
    split_word(it.offset_x, mg[0], ng[0]);
    split_word(it.offset_y, mg[1], ng[1]);
    split_word(it.offset_z, mg[2], ng[2]);
    big = 0;
    for (int i = 0; i < 3; i++) if (mg[i] > big) big = mg[i];
    if (big == 0) return;
    bl = 0;
    tmp = big;
    while (tmp != 0) begin
      bl++;
      tmp = tmp >> 1;
    end
    sh = 21 - bl;
    for (int i = 0; i < 3; i++) a[i] = (sh >= 0) ? (mg[i] << sh) : (mg[i] >> (-sh));
    len2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    for (int p = 0; p < 6; p++) begin
      t = ((a[ROW[p]] * a[COL[p]]) << 20) / len2;
      mat_sum[p] = sat_sum(mat_sum[p], t, ng[ROW[p]] != ng[COL[p]]);
    end
    split_word(it.value_difference, vm, vn);
    s = sh - 10;
    for (int i = 0; i < 3; i++) begin
      w = (a[i] << 42) / len2;
      prod = w * vm;
      mag = (s >= 0) ? (prod << s) : (prod >> (-s));
      rhs_sum[i] = sat_sum(rhs_sum[i], mag, ng[i] != vn);
    end
  endfunction

  // min(floor(n * 2^e / d), cap)
  function automatic logic [63:0] scaled_div(logic [63:0] n, logic [63:0] d, int e,
                                             logic [63:0] cap);
    logic [63:0] q, rem;
    q = n / d;
    rem = n % d;
    if (e < 0) begin
      q = (-e >= 64) ? 64'd0 : (q >> (-e));
      return (q > cap) ? cap : q;
    end
    if (q > cap) return cap;
    for (int b = 0; b < e; b++) begin
      q = q << 1;
      rem = rem << 1;
      if (rem >= d) begin
        q++;
        rem = rem - d;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic logic [GRD_W-1:0] grad_part(longint num, longint det, int e);
    logic [63:0] nm, dm, q;
    bit          nn, dn, neg;
    longint      g;
    split_long(num, nm, nn);
    split_long(det, dm, dn);
    neg = nn != dn;
    q = scaled_div(nm, dm, e, neg ? GRAD_NEG : GRAD_POS);
    g = neg ? -longint'(q) : longint'(q);
    return g[GRD_W-1:0];
  endfunction

  // cofactor solve of the accumulated system
  function automatic result_t solve_gradient();
    result_t     res;
    logic [63:0] dg [3];
    logic [63:0] rm [3];
    logic [63:0] mag, trace, cube, thr, rbig;
    longint      m [6];
    longint      rs [3];
    longint      cx, cy, cz, c22, c23, c33, det;
    bit          neg;
    bit          rn [3];
    int          k, r, e;
    res = '0;
    dg[0] = mat_sum[0] < 0 ? 64'd0 : mat_sum[0];
    dg[1] = mat_sum[3] < 0 ? 64'd0 : mat_sum[3];
    dg[2] = mat_sum[5] < 0 ? 64'd0 : mat_sum[5];
    k = 0;
    while (k < 63 && !((dg[0] >> k) < TERM_LIM && (dg[1] >> k) < TERM_LIM &&
                       (dg[2] >> k) < TERM_LIM &&
                       (dg[0] >> k) + (dg[1] >> k) + (dg[2] >> k) < TERM_LIM))
      k++;
    for (int p = 0; p < 6; p++) begin
      split_long(mat_sum[p], mag, neg);
      mag = mag >> k;
      if (mag > TERM_LIM - 1) mag = TERM_LIM - 1;
      if (ROW[p] == COL[p] && neg) mag = 0;
      m[p] = neg ? -longint'(mag) : longint'(mag);
    end
    trace = m[0] + m[3] + m[5];
    if (trace == 0) return res;
    cx  = m[3] * m[5] - m[4] * m[4];
    cy  = m[2] * m[4] - m[1] * m[5];
    cz  = m[1] * m[4] - m[3] * m[2];
    c22 = m[0] * m[5] - m[2] * m[2];
    c23 = m[1] * m[2] - m[0] * m[4];
    c33 = m[0] * m[3] - m[1] * m[1];
    det = m[0] * cx + m[1] * cy + m[2] * cz;
    cube = trace * trace * trace;
    thr = (cube + DET_DIV - 1) / DET_DIV;
    split_long(det, mag, neg);
    if (mag < thr) return res;
    rbig = 0;
    for (int i = 0; i < 3; i++) begin
      split_long(rhs_sum[i], rm[i], rn[i]);
      if (rm[i] > rbig) rbig = rm[i];
    end
    r = 0;
    while ((rbig >> r) >= RHS_BOUND) r++;
    for (int i = 0; i < 3; i++) rs[i] = rn[i] ? -longint'(rm[i] >> r) : longint'(rm[i] >> r);
    e = 20 - k + r;
    res.grad_x = grad_part(cx * rs[0] + cy * rs[1] + cz * rs[2], det, e);
    res.grad_y = grad_part(cy * rs[0] + c22 * rs[1] + c23 * rs[2], det, e);
    res.grad_z = grad_part(cz * rs[0] + c23 * rs[1] + c33 * rs[2], det, e);
    res.gradient_valid = 1'b1;
    return res;
  endfunction

  function automatic void clear_sums();
    for (int i = 0; i < 6; i++) mat_sum[i] = 0;
    for (int i = 0; i < 3; i++) rhs_sum[i] = 0;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    include_boundary = 1'b1;
    clear_sums();
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      include_boundary = 1'b1;
      clear_sums();
    end else begin
      if (cfg_write_en) include_boundary = cfg_write_data;
      // input transfer: fold entry in, solve on the last one
      if (item_valid && !item_stall) begin
        if (!(item.is_boundary && !include_boundary)) accumulate_entry(item);
        if (item.last_entry) begin
          gradient_queue = {gradient_queue, solve_gradient()};
          clear_sums();
        end
      end
      // output transfer: compare with oldest expectation
      if (result_valid && !result_stall) begin
        got = result;
        if (gradient_queue.size() == 0) begin
          $error("unexpected gradient result %h", got);
          errors++;
        end else begin
          want = gradient_queue.pop_front();
          if (got.grad_x !== want.grad_x) begin
            $error("grad_x expected %h got %h", want.grad_x, got.grad_x);
            errors++;
          end
          if (got.grad_y !== want.grad_y) begin
            $error("grad_y expected %h got %h", want.grad_y, got.grad_y);
            errors++;
          end
          if (got.grad_z !== want.grad_z) begin
            $error("grad_z expected %h got %h", want.grad_z, got.grad_z);
            errors++;
          end
          if (got.gradient_valid !== want.gradient_valid) begin
            $error("gradient_valid expected %b got %b", want.gradient_valid,
                   got.gradient_valid);
            errors++;
          end
        end
      end
    end
    pending = gradient_queue.size();
  end

endmodule

/* test/testbench.sv */
// stimulus, flow control and verdict for the gradient core
`timescale 1ns / 1ps
module testbench;
  import wlsg_pkg::*;

  localparam int SETTLE_CYCLES = 320;
  localparam int STALL_LIMIT   = 4000;

  logic    clk;
  logic    rst;
  logic    cfg_write_en;
  logic    cfg_write_data;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;
  int      errors;
  int      pending;
  int      idle_cycles;
  int      sent;

  weighted_least_squares_cell_gradient_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

  gradient_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .item           (item),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result),
    .errors         (errors),
    .pending        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog on cycles without any transfer
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: one long hold-off first, then random stalls
  initial begin
    int pick;
    result_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    result_stall = 1'b1;
    repeat (700) @(negedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        result_stall = 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end else if (pick < 85) begin
        result_stall = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        result_stall = 1'b1;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end
    end
  end

  function automatic item_t make_entry(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                       logic [31:0] v, bit bnd, bit last);
    item_t it;
    it.offset_x = x;
    it.offset_y = y;
    it.offset_z = z;
    it.value_difference = v;
    it.is_boundary = bnd;
    it.last_entry = last;
    return it;
  endfunction

  // offsets and values over many scales, extremes included
  function automatic logic [31:0] random_word();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 32'h8000_0000;
    if (pick == 1) return 32'h7fff_ffff;
    if (pick < 4) return 32'd0;
    return $signed($urandom) >>> $urandom_range(0, 30);
  endfunction

  // transfer one entry, with a random gap ahead of it
  task automatic send_entry(item_t it);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick >= 60) begin
      item_valid = 1'b0;
      repeat (pick < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk);
    end
    item_valid = 1'b1;
    item = it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    item_valid = 1'b0;
    sent++;
  endtask

  // wait for all results, then let the block drain
  task automatic drain_idle();
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(bit val);
    cfg_write_en = 1'b1;
    cfg_write_data = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
  endtask

  // one random stencil; a few are flat to make the matrix deficient
  task automatic send_stencil();
    int     n;
    bit     flat;
    logic [31:0] z;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
    flat = $urandom_range(0, 9) == 0;
    for (int i = 0; i < n; i++) begin
      z = flat ? 32'd0 : random_word();
      send_entry(make_entry(random_word(), random_word(), z, random_word(),
                            $urandom_range(0, 3) == 0, i == n - 1));
    end
  endtask

  task automatic random_phase(int count);
    int target;
    target = sent + count;
    while (sent < target) begin
      if ($urandom_range(0, 19) == 0) begin
        // noise: a lone entry that closes a stencil of its own
        send_entry(make_entry(random_word(), random_word(), random_word(), $urandom,
                              1'($urandom_range(0, 1)), 1'b1));
      end else begin
        send_stencil();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = 1'b0;
    item_valid = 1'b0;
    item = '0;
    sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_mode(1'b1);

    // axis-aligned unit stencil, boundary entry included
    send_entry(make_entry(32'h0100_0000, 0, 0, 32'h0001_0000, 0, 0));
    send_entry(make_entry(0, 32'h0100_0000, 0, 32'hfffe_0000, 1, 0));
    send_entry(make_entry(0, 0, 32'h0100_0000, 32'h0003_0000, 0, 1));
    // field extremes
    send_entry(make_entry(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
    send_entry(make_entry(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
    send_entry(make_entry(32'h0000_0001, 0, 0, 32'h8000_0000, 0, 0));
    send_entry(make_entry(0, 32'hffff_ffff, 0, 32'h7fff_ffff, 1, 0));
    send_entry(make_entry(0, 0, 32'h7fff_ffff, 32'hffff_ffff, 0, 1));
    // tiny offsets with large values drive the gradient into saturation
    send_entry(make_entry(32'h0000_0001, 0, 0, 32'h7fff_ffff, 0, 0));
    send_entry(make_entry(0, 32'h0000_0001, 0, 32'h8000_0000, 0, 0));
    send_entry(make_entry(0, 0, 32'h0000_0001, 32'h7fff_ffff, 0, 1));
    // empty stencil: zero offset only
    send_entry(make_entry(0, 0, 0, 32'h0005_0000, 0, 1));
    // single entry: deficient matrix
    send_entry(make_entry(32'h0200_0000, 32'h0100_0000, 0, 32'h0001_0000, 0, 1));
    // zero offset inside an otherwise full stencil
    send_entry(make_entry(32'h0100_0000, 32'h0010_0000, 0, 32'h0002_0000, 0, 0));
    send_entry(make_entry(0, 0, 0, 32'h7fff_ffff, 0, 0));
    send_entry(make_entry(32'hff00_0000, 32'h0100_0000, 32'h0080_0000, 32'h0001_0000, 0, 0));
    send_entry(make_entry(0, 32'hff00_0000, 32'h0100_0000, 32'hffff_0000, 0, 1));
    drain_idle();

    // boundary entries disabled, one of them closing the stencil
    write_mode(1'b0);
    send_entry(make_entry(32'h0100_0000, 0, 0, 32'h0001_0000, 0, 0));
    send_entry(make_entry(0, 32'h0100_0000, 0, 32'h0002_0000, 0, 0));
    send_entry(make_entry(0, 0, 32'h0100_0000, 32'h0003_0000, 0, 0));
    send_entry(make_entry(32'h0100_0000, 32'h0100_0000, 0, 32'h7fff_0000, 1, 1));
    send_entry(make_entry(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0001_0000, 1, 1));
    random_phase(170);
    drain_idle();

    write_mode(1'b1);
    random_phase(200);
    drain_idle();

    write_mode(1'b0);
    random_phase(150);

    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* weighted_least_squares_cell_gradient_core.f */
rtl/wlsg_pkg.sv
rtl/wlsg_front.sv
rtl/wlsg_queue.sv
rtl/wlsg_accum.sv
rtl/wlsg_solve.sv
rtl/weighted_least_squares_cell_gradient_core.sv
rtl/wlsg_checker.sv
test/gradient_checker.sv
test/testbench.sv
